FILE: rtl/core/bffe_pkg.sv
`default_nettype none

package bffe_pkg;

  localparam int MAX_BITS_DEF  = 1024;
  localparam int WORD_BITS_DEF = 32;

  localparam int IDX_W      = 10;  // bit_index and found_index
  localparam int COUNT_W    = 11;  // bit_count register
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_BIT_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FILL_ONES = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    K_READ       = 3'd0,
    K_SET        = 3'd1,
    K_CLEAR      = 3'd2,
    K_TOGGLE     = 3'd3,
    K_WRITE      = 3'd4,
    K_FIND_CLEAR = 3'd5,
    K_FIND_SET   = 3'd6,
    K_REFILL     = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BIT,
    ST_SCAN,
    ST_FILL
  } state_t;

  typedef struct packed {
    kind_t             kind;
    logic [IDX_W-1:0]  bit_index;
    logic              bit_value;
    logic              idx_err;
  } req_t;

  typedef struct packed {
    logic              read_bit;
    logic              found;
    logic [IDX_W-1:0]  found_index;
    logic              index_error;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/core/bffe_ram.sv
`default_nettype none

module bffe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/core/bffe_ctrl.sv
`default_nettype none

module bffe_ctrl #(
  parameter int MAX_BITS  = bffe_pkg::MAX_BITS_DEF,
  parameter int WORD_BITS = bffe_pkg::WORD_BITS_DEF,
  localparam int NUM_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS,
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1,
  localparam int NEED_W    = $clog2(MAX_BITS + WORD_BITS + 1),
  localparam int CNT_W     = (NEED_W > bffe_pkg::COUNT_W) ? NEED_W : bffe_pkg::COUNT_W
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 accept,
  input  wire bffe_pkg::req_t       req,
  input  wire logic [CNT_W-1:0]     biu,
  input  wire logic                 fill_ones,
  output logic                      busy,
  output logic                      ram_we,
  output logic [AW-1:0]             ram_waddr,
  output logic [WORD_BITS-1:0]      ram_wdata,
  output logic [AW-1:0]             ram_raddr,
  input  wire logic [WORD_BITS-1:0] ram_rdata,
  output logic                      done,
  output bffe_pkg::res_t            res
);

  import bffe_pkg::*;

  localparam int BW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  // word = bit_index / WORD_BITS via a reciprocal, exact for 10-bit indexes
  localparam int SH = IDX_W + BW;
  localparam int RECIP = ((1 << SH) + WORD_BITS - 1) / WORD_BITS;
  localparam int PW = IDX_W + SH + 1;

  state_t                state, state_next;
  kind_t                 kind_r, kind_r_next;
  logic [IDX_W-1:0]      idx_r, idx_r_next;
  logic                  val_r, val_r_next;
  logic                  err_r, err_r_next;
  logic [AW-1:0]         word_r, word_r_next;
  logic [AW-1:0]         ptr, ptr_next;
  logic [CNT_W-1:0]      base, base_next;
  logic                  pend, pend_next;
  logic                  done_next;
  res_t                  res_next;

  logic [PW-1:0]         prod;
  logic [IDX_W-1:0]      quot;
  logic [IDX_W-1:0]      word_start;
  logic [BW-1:0]         bpos;
  logic [WORD_BITS-1:0]  bmask;
  logic [WORD_BITS-1:0]  bit_word;
  logic [WORD_BITS-1:0]  hit;
  logic [CNT_W-1:0]      base_step;

  function automatic logic [BW-1:0] lowest_one(input logic [WORD_BITS-1:0] v);
    logic [BW-1:0] p;
    p = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) p = BW'(i);
    end
    return p;
  endfunction

  assign prod       = PW'(req.bit_index) * PW'(RECIP);
  assign quot       = prod[SH +: IDX_W];
  assign word_start = IDX_W'(word_r * WORD_BITS);
  assign bpos       = BW'(idx_r - word_start);
  assign bmask      = WORD_BITS'(1) << bpos;
  assign hit        = (kind_r == K_FIND_SET) ? ram_rdata : ~ram_rdata;
  assign base_step  = base + CNT_W'(WORD_BITS);
  assign busy       = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      ptr   <= '0;
      pend  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      ptr   <= ptr_next;
      pend  <= pend_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_r_next;
    idx_r  <= idx_r_next;
    val_r  <= val_r_next;
    err_r  <= err_r_next;
    word_r <= word_r_next;
    base   <= base_next;
    res    <= res_next;
  end

  always_comb begin
    state_next  = state;
    kind_r_next = kind_r;
    idx_r_next  = idx_r;
    val_r_next  = val_r;
    err_r_next  = err_r;
    word_r_next = word_r;
    ptr_next    = ptr;
    base_next   = base;
    pend_next   = pend;
    done_next   = 1'b0;
    res_next    = '0;
    ram_we      = 1'b0;
    ram_waddr   = ptr;
    ram_wdata   = '0;
    ram_raddr   = '0;
    bit_word    = ram_rdata;

    case (state)
      ST_CLEAR: begin
        // wipe the store after reset, one word a cycle
        ram_we = 1'b1;
        if (ptr == AW'(NUM_WORDS - 1)) begin
          state_next = ST_IDLE;
        end else begin
          ptr_next = ptr + AW'(1);
        end
      end

      ST_IDLE: begin
        if (accept) begin
          kind_r_next = req.kind;
          idx_r_next  = req.bit_index;
          val_r_next  = req.bit_value;
          err_r_next  = req.idx_err;
          word_r_next = AW'(quot);
          case (req.kind)
            K_FIND_CLEAR, K_FIND_SET: begin
              state_next = ST_SCAN;
              ptr_next   = '0;
              base_next  = '0;
              pend_next  = (biu != '0);
            end
            K_REFILL: begin
              state_next = ST_FILL;
              ptr_next   = '0;
              base_next  = '0;
            end
            default: begin
              state_next = ST_BIT;
              ram_raddr  = AW'(quot);
            end
          endcase
        end
      end

      ST_BIT: begin
        case (kind_r)
          K_SET:    bit_word = ram_rdata | bmask;
          K_CLEAR:  bit_word = ram_rdata & ~bmask;
          K_TOGGLE: bit_word = ram_rdata ^ bmask;
          K_WRITE:  bit_word = val_r ? (ram_rdata | bmask) : (ram_rdata & ~bmask);
          default:  bit_word = ram_rdata;
        endcase
        ram_we               = !err_r && (kind_r != K_READ);
        ram_waddr            = word_r;
        ram_wdata            = bit_word;
        done_next            = 1'b1;
        res_next.index_error = err_r;
        res_next.read_bit    = !err_r && (kind_r == K_READ) && ((ram_rdata & bmask) != '0);
        state_next           = ST_IDLE;
      end

      ST_SCAN: begin
        // ptr/base describe the word whose data arrives this cycle
        ram_raddr = ptr + AW'(1);
        if (pend && (hit != '0)) begin
          done_next            = 1'b1;
          res_next.found       = 1'b1;
          res_next.found_index = IDX_W'(base + CNT_W'(lowest_one(hit)));
          state_next           = ST_IDLE;
        end else if (!pend) begin
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end else begin
          ptr_next  = ptr + AW'(1);
          base_next = base_step;
          pend_next = (base_step < biu);
        end
      end

      ST_FILL: begin
        if (base < biu) begin
          ram_we    = 1'b1;
          ram_waddr = ptr;
          ram_wdata = fill_ones ? '1 : '0;
          ptr_next  = ptr + AW'(1);
          base_next = base_step;
        end else begin
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/bitmap_find_first_engine_core.sv
`default_nettype none
// Bitmap engine: read, set, clear, toggle or write one bit, find the lowest
// clear or set bit, or refill the words in use with a fill pattern.
//
// Request channel: an item is taken on a rising edge with start high and busy
// low. busy stays high until the item's result has been registered.
// Result channel: done is high for one cycle with read_bit, found,
// found_index and index_error. There is no back-pressure on results.
// Config channel: cfg_ready is always high; index 0 is bit_count (saturated
// to MAX_BITS), index 1 is fill_ones. Other indexes are ignored.
//
// Timing: a bit operation is one read-modify-write of a word in the single
// RAM. A find reads one word per cycle, up to ceil(bit_count / WORD_BITS)
// words; a refill writes one word per cycle, ceil(bit_count / WORD_BITS)
// words. Only one item is in flight, so a read never overlaps a write to the
// same word.
// Reset: the RAM is cleared one word a cycle, NUM_WORDS words (32 by default)
// with busy high; bit_count returns to min(MAX_BITS, 1024), fill_ones to 0.

module bitmap_find_first_engine_core #(
  parameter int MAX_BITS  = bffe_pkg::MAX_BITS_DEF,
  parameter int WORD_BITS = bffe_pkg::WORD_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [2:0]                     kind,
  input  wire logic [bffe_pkg::IDX_W-1:0]     bit_index,
  input  wire logic                           bit_value,
  output logic                                done,
  output logic                                read_bit,
  output logic                                found,
  output logic [bffe_pkg::IDX_W-1:0]          found_index,
  output logic                                index_error,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [bffe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bffe_pkg::CFG_DATA_W-1:0] cfg_data
);

  import bffe_pkg::*;

  localparam int NUM_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int NEED_W    = $clog2(MAX_BITS + WORD_BITS + 1);
  localparam int CNT_W     = (NEED_W > COUNT_W) ? NEED_W : COUNT_W;
  localparam int BIU_RST   = (MAX_BITS < 1024) ? MAX_BITS : 1024;

  logic [CNT_W-1:0]     biu;
  logic [CNT_W-1:0]     cfg_count;
  logic                 fill_ones;
  logic                 accept;
  req_t                 req;
  res_t                 res;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  assign cfg_ready = 1'b1;
  assign cfg_count = CNT_W'(cfg_data);

  // bits in use, held already saturated
  always_ff @(posedge clk) begin
    if (rst) begin
      biu       <= CNT_W'(BIU_RST);
      fill_ones <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_BIT_COUNT) begin
        biu <= (cfg_count > CNT_W'(MAX_BITS)) ? CNT_W'(MAX_BITS) : cfg_count;
      end else if (cfg_index == REG_FILL_ONES) begin
        fill_ones <= cfg_data[0];
      end
    end
  end

  assign accept        = start && !busy;
  assign req.kind      = kind_t'(kind);
  assign req.bit_index = bit_index;
  assign req.bit_value = bit_value;
  assign req.idx_err   = (kind_t'(kind) <= K_WRITE) && (CNT_W'(bit_index) >= biu);

  bffe_ctrl #(
    .MAX_BITS  (MAX_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .req       (req),
    .biu       (biu),
    .fill_ones (fill_ones),
    .busy      (busy),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .done      (done),
    .res       (res)
  );

  bffe_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign read_bit    = res.read_bit;
  assign found       = res.found;
  assign found_index = res.found_index;
  assign index_error = res.index_error;

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without an item in flight");

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    (done && index_error) |-> (!found && !read_bit))
    else $error("index error with read or find result");

  a_bit_op_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (kind <= K_WRITE)) |-> ##2 done)
    else $error("bit operation result late");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepting an item");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import bffe_pkg::*;

  // cfg index past the end of the register list; writes to it are dropped
  localparam logic [CFG_IDX_W-1:0] REG_NONE = '1;
  localparam int RANDOM_PHASES = 9;
  localparam int PHASE_ITEMS = 200;

  class bitmap_mirror;
    logic [WORD_BITS_DEF-1:0] words [MAX_BITS_DEF / WORD_BITS_DEF];
    int unsigned count;
    bit fill;
    res_t owed [$];
    int errors;

    function new();
      foreach (words[i]) words[i] = '0;
      count = MAX_BITS_DEF;
      fill = 1'b0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_BIT_COUNT) count = data;
      else if (idx == REG_FILL_ONES) fill = data[0];
    endfunction

    function void take_request(kind_t k, logic [IDX_W-1:0] idx, logic v);
      res_t r;
      int unsigned in_use;
      int unsigned nwords;
      int unsigned w;
      logic want;
      r = '0;
      in_use = (count > MAX_BITS_DEF) ? MAX_BITS_DEF : count;
      nwords = (in_use + WORD_BITS_DEF - 1) / WORD_BITS_DEF;
      w = idx / WORD_BITS_DEF;
      case (k)
        K_READ, K_SET, K_CLEAR, K_TOGGLE, K_WRITE: begin
          if (idx >= in_use) begin
            r.index_error = 1'b1;
          end else begin
            case (k)
              K_READ:   r.read_bit = words[w][idx % WORD_BITS_DEF];
              K_SET:    words[w][idx % WORD_BITS_DEF] = 1'b1;
              K_CLEAR:  words[w][idx % WORD_BITS_DEF] = 1'b0;
              K_TOGGLE: words[w][idx % WORD_BITS_DEF] = ~words[w][idx % WORD_BITS_DEF];
              default:  words[w][idx % WORD_BITS_DEF] = v;
            endcase
          end
        end
        K_FIND_CLEAR, K_FIND_SET: begin
          want = (k == K_FIND_SET);
          // scan covers the spare tail bits of the last word in use
          for (int i = 0; i < nwords; i++) begin
            for (int b = 0; b < WORD_BITS_DEF; b++) begin
              if (!r.found && words[i][b] == want) begin
                r.found = 1'b1;
                r.found_index = IDX_W'(i * WORD_BITS_DEF + b);
              end
            end
          end
        end
        default: begin
          for (int i = 0; i < nwords; i++) words[i] = fill ? '1 : '0;
        end
      endcase
      owed.push_back(r);
    endfunction

    function void flag(string msg);
      if (errors < 10) $display("%s", msg);
      errors++;
    endfunction

    function void match_result(res_t got);
      res_t want;
      if (owed.size() == 0) begin
        flag($sformatf("unexpected result rd=%0d fnd=%0d idx=%0d err=%0d",
                       got.read_bit, got.found, got.found_index, got.index_error));
        return;
      end
      want = owed.pop_front();
      if (got.read_bit !== want.read_bit || got.found !== want.found ||
          got.found_index !== want.found_index || got.index_error !== want.index_error)
        flag($sformatf({"mismatch: want rd=%0d fnd=%0d idx=%0d err=%0d,",
                        " got rd=%0d fnd=%0d idx=%0d err=%0d"},
                       want.read_bit, want.found, want.found_index, want.index_error,
                       got.read_bit, got.found, got.found_index, got.index_error));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [2:0] kind = '0;
  logic [IDX_W-1:0] bit_index = '0;
  logic bit_value = 1'b0;
  logic done;
  logic read_bit;
  logic found;
  logic [IDX_W-1:0] found_index;
  logic index_error;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bitmap_mirror mirror = new();
  int idle_pct = 0;
  int bits_live = MAX_BITS_DEF;

  bitmap_find_first_engine_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .kind(kind), .bit_index(bit_index), .bit_value(bit_value),
    .done(done), .read_bit(read_bit), .found(found),
    .found_index(found_index), .index_error(index_error),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // result is checked before the item taken on the same edge is noted
  always @(posedge clk) begin
    res_t got;
    if (!rst) begin
      if (done === 1'b1) begin
        got.read_bit = read_bit;
        got.found = found;
        got.found_index = found_index;
        got.index_error = index_error;
        mirror.match_result(got);
      end
      if (start && busy === 1'b0) mirror.take_request(kind_t'(kind), bit_index, bit_value);
      if (cfg_valid && cfg_ready === 1'b1) mirror.write_reg(cfg_index, cfg_data);
    end
  end

  task automatic send_item(kind_t k, logic [IDX_W-1:0] idx, logic v);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    kind <= k;
    bit_index <= idx;
    bit_value <= v;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (mirror.owed.size() != 0 || busy !== 1'b0);
  endtask

  // leaves cfg_valid high so back-to-back writes need no extra edge
  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
  endtask

  task automatic configure(int unsigned count, bit fill);
    drain();
    set_reg(REG_NONE, '1);
    set_reg(REG_BIT_COUNT, CFG_DATA_W'(count));
    set_reg(CFG_IDX_W'($urandom_range(2, 14)), CFG_DATA_W'($urandom));
    set_reg(REG_FILL_ONES, CFG_DATA_W'(fill));
    cfg_valid <= 1'b0;
    bits_live = (count > MAX_BITS_DEF) ? MAX_BITS_DEF : count;
  endtask

  task automatic random_item();
    int unsigned pick;
    logic [IDX_W-1:0] idx;
    pick = $urandom_range(99);
    if (bits_live > 0 && $urandom_range(99) < 85) idx = IDX_W'($urandom_range(bits_live - 1));
    else idx = IDX_W'($urandom_range(MAX_BITS_DEF - 1));
    if (pick < 12) send_item(K_FIND_CLEAR, idx, 1'($urandom_range(1)));
    else if (pick < 24) send_item(K_FIND_SET, idx, 1'($urandom_range(1)));
    else if (pick < 29) send_item(K_REFILL, idx, 1'($urandom_range(1)));
    else send_item(kind_t'($urandom_range(4)), idx, 1'($urandom_range(1)));
  endtask

  initial begin
    int unsigned counts [RANDOM_PHASES];
    bit fills [RANDOM_PHASES];
    counts = '{1024, 1, 33, 2047, 0, 32, $urandom_range(1, 1023), 1024,
               $urandom_range(1, 2047)};
    fills = '{0, 1, 1, 0, 1, 0, 1'($urandom_range(1)), 1, 1'($urandom_range(1))};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: full width, default fill of zeros
    send_item(K_READ, 0, 0);
    send_item(K_SET, 0, 0);
    send_item(K_READ, 0, 0);
    send_item(K_SET, 1023, 0);
    send_item(K_READ, 1023, 0);
    send_item(K_FIND_SET, 0, 0);
    send_item(K_CLEAR, 0, 0);
    send_item(K_FIND_SET, 1023, 1);
    send_item(K_TOGGLE, 1023, 0);
    send_item(K_FIND_SET, 0, 0);
    send_item(K_FIND_CLEAR, 0, 0);
    send_item(K_WRITE, 512, 1);
    send_item(K_READ, 512, 0);
    send_item(K_WRITE, 512, 0);
    send_item(K_TOGGLE, 31, 1);
    send_item(K_FIND_SET, 0, 0);
    send_item(K_REFILL, 0, 0);
    send_item(K_FIND_SET, 0, 0);
    // two words in use, tail bits of word 1 included in the scan
    configure(33, 1);
    send_item(K_REFILL, 0, 0);
    send_item(K_FIND_CLEAR, 0, 0);
    send_item(K_READ, 33, 0);
    send_item(K_TOGGLE, 32, 0);
    send_item(K_FIND_CLEAR, 0, 0);
    // nothing in use
    configure(0, 0);
    send_item(K_FIND_SET, 0, 0);
    send_item(K_REFILL, 0, 0);
    send_item(K_SET, 0, 1);
    // over-range count saturates; words past the earlier refill kept zeros
    configure(2047, 0);
    send_item(K_FIND_CLEAR, 0, 0);
    send_item(K_READ, 1023, 0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      configure(counts[p], fills[p]);
      idle_pct = (p < 3) ? 35 : (p < 6) ? 46 : 0;
      repeat (PHASE_ITEMS) random_item();
    end

    drain();
    repeat (40) @(posedge clk);
    while (mirror.owed.size() != 0) begin
      void'(mirror.owed.pop_front());
      mirror.flag("expected result never arrived");
    end
    if (mirror.errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/bffe_pkg.sv
rtl/core/bffe_ram.sv
rtl/core/bffe_ctrl.sv
rtl/core/bitmap_find_first_engine_core.sv
tb/tb_top.sv
